@@ src/mkl_pkg.sv @@
// ----------------------------------------------------------------------------
// mkl_pkg
// Shared widths, codes and defaults for the MAC kind lookup table.
// ----------------------------------------------------------------------------
`default_nettype none

package mkl_pkg;

  localparam int MAC_W  = 48;
  localparam int KIND_W = 8;
  localparam int CNT_W  = 4;
  localparam int REQ_W  = 2;
  localparam int ST_W   = 2;

  // Default number of table slots.
  localparam int SLOT_COUNT_DEF = 8;

  // Most result beats that one list request may produce.
  localparam logic [CNT_W-1:0] MAX_RESULTS = 4'd8;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_SET    = 2'd1,
    REQ_LIST   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  localparam logic [ST_W-1:0] ST_DONE = 2'd0;
  localparam logic [ST_W-1:0] ST_SAME = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

endpackage

`default_nettype wire

@@ src/mkl_req_if.sv @@
// ----------------------------------------------------------------------------
// mkl_req_if
// Request channel: one beat carries one table request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkl_req_if;
  logic                       valid;
  logic                       ready;
  logic [mkl_pkg::REQ_W-1:0]  req_type;
  logic [mkl_pkg::MAC_W-1:0]  mac_key;
  logic [mkl_pkg::KIND_W-1:0] kind_value;
  logic [mkl_pkg::CNT_W-1:0]  list_cap;

  modport source (output valid, req_type, mac_key, kind_value, list_cap, input ready);
  modport sink   (input valid, req_type, mac_key, kind_value, list_cap, output ready);
endinterface

`default_nettype wire

@@ src/mkl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mkl_rsp_if
// Result channel: one beat carries one result of a table request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkl_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [mkl_pkg::ST_W-1:0]   status;
  logic [mkl_pkg::KIND_W-1:0] kind_out;
  logic [mkl_pkg::MAC_W-1:0]  mac_out;
  logic                       entry_valid;
  logic [mkl_pkg::CNT_W-1:0]  entry_count;
  logic                       last;

  modport source (output valid, status, kind_out, mac_out, entry_valid, entry_count, last,
                  input ready);
  modport sink   (input valid, status, kind_out, mac_out, entry_valid, entry_count, last,
                  output ready);
endinterface

`default_nettype wire

@@ src/mkl_ram.sv @@
// ----------------------------------------------------------------------------
// mkl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mkl_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/mac_kind_lookup_table_top.sv @@
// ----------------------------------------------------------------------------
// mac_kind_lookup_table_top
// Fully associative MAC-to-kind table with lookup, set, list and clear.
// ----------------------------------------------------------------------------
// Timing: a lookup or set walks the slots and answers once the walk ends,
//   earlier on a hit; clear and an empty list skip the walk, and a list
//   entry leaves as the walk reaches its slot.
// Throughput: one request at a time with one RAM read per cycle; the walk
//   holds while a list entry waits for the output register.
// Reset: the used marks clear at once; the key and kind RAM is never cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_kind_lookup_table_top #(
  parameter int SLOT_COUNT = mkl_pkg::SLOT_COUNT_DEF
) (
  input wire logic clk,
  input wire logic rst,
  mkl_req_if.sink   req,
  mkl_rsp_if.source rsp
);

  // Address width of a slot index, and a counter width that can also hold
  // SLOT_COUNT itself to mark the end of the walk.
  localparam int AW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW     = $clog2(SLOT_COUNT + 1);
  localparam int WORD_W = mkl_pkg::MAC_W + mkl_pkg::KIND_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;

  // The used marks live in flip-flops so that reset and clear empty the table
  // at once; keys and kinds live in the RAM.
  logic [SLOT_COUNT-1:0] used;

  // Captured request.
  mkl_pkg::req_t              req_q;
  logic [mkl_pkg::MAC_W-1:0]  key_q;
  logic [mkl_pkg::KIND_W-1:0] kval_q;
  logic [mkl_pkg::CNT_W-1:0]  cap_q;

  // Walk state. idx is the next slot to read; pidx is the slot whose RAM data
  // arrives this cycle, and pend says that this data is meaningful.
  logic [CW-1:0]              idx;
  logic [AW-1:0]              pidx;
  logic                       pend;
  logic [mkl_pkg::CNT_W-1:0]  cnt;

  // Search results gathered by the walk for lookup and set.
  logic                       match;
  logic [AW-1:0]              midx;
  logic [mkl_pkg::KIND_W-1:0] mkind;
  logic                       free_found;
  logic [AW-1:0]              fidx;

  // Output register.
  logic                       out_valid;
  logic [mkl_pkg::ST_W-1:0]   out_status;
  logic [mkl_pkg::KIND_W-1:0] out_kind;
  logic [mkl_pkg::MAC_W-1:0]  out_mac;
  logic                       out_entry_valid;
  logic [mkl_pkg::CNT_W-1:0]  out_count;
  logic                       out_last;

  // RAM ports.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [mkl_pkg::MAC_W-1:0]  rd_mac;
  logic [mkl_pkg::KIND_W-1:0] rd_kind;
  logic                       cur_used;
  logic                       hit;
  logic                       list_emit;
  logic                       advance;
  logic                       at_end;
  logic                       space;
  logic [SLOT_COUNT-1:0]      above;
  logic                       list_last;
  logic [mkl_pkg::CNT_W-1:0]  cap_sat;
  logic                       list_empty;

  mkl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_COUNT),
    .ADDR_W(AW)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign req.ready = (state == S_IDLE);

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.kind_out    = out_kind;
  assign rsp.mac_out     = out_mac;
  assign rsp.entry_valid = out_entry_valid;
  assign rsp.entry_count = out_count;
  assign rsp.last        = out_last;

  // The output register can take a new beat when it is empty or is being
  // drained in this same cycle.
  assign space = !out_valid || rsp.ready;

  assign cap_sat = (req.list_cap > mkl_pkg::MAX_RESULTS) ? mkl_pkg::MAX_RESULTS
                                                          : req.list_cap;
  assign list_empty = (cap_sat == '0) || (used == '0);

  assign rd_mac  = ram_rdata[mkl_pkg::KIND_W +: mkl_pkg::MAC_W];
  assign rd_kind = ram_rdata[mkl_pkg::KIND_W-1:0];

  assign cur_used  = pend && used[pidx];
  assign hit       = cur_used && (rd_mac == key_q);
  assign list_emit = (req_q == mkl_pkg::REQ_LIST) && cur_used;
  assign at_end    = (idx == CW'(SLOT_COUNT));

  // A list entry that cannot leave yet holds the walk, and the RAM re-reads
  // the same slot so its data is still there next cycle.
  assign advance   = !(list_emit && !space);
  assign ram_raddr = advance ? idx[AW-1:0] : pidx;

  // A listed entry is the last one when it fills the cap or when no used
  // slot follows it. The used marks do not change during a list.
  always_comb begin
    for (int j = 0; j < SLOT_COUNT; j++) begin
      above[j] = used[j] && (AW'(j) > pidx);
    end
  end
  assign list_last = ((cnt + 4'd1) == cap_q) || (above == '0);

  // RAM write: a set either rewrites the kind of the matching slot or
  // claims the lowest free slot, once the walk has finished.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = match ? midx : fidx;
    ram_wdata = {key_q, kval_q};
    if (state == S_FINISH && space && req_q == mkl_pkg::REQ_SET) begin
      if (match) begin
        ram_we = (mkind != kval_q);
      end else begin
        ram_we = free_found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_q      <= mkl_pkg::req_t'(req.req_type);
            key_q      <= req.mac_key;
            kval_q     <= req.kind_value;
            cap_q      <= cap_sat;
            idx        <= '0;
            pend       <= 1'b0;
            cnt        <= '0;
            match      <= 1'b0;
            free_found <= 1'b0;
            if (req.req_type == mkl_pkg::REQ_CLEAR) begin
              state <= S_FINISH;
            end else if (req.req_type == mkl_pkg::REQ_LIST && list_empty) begin
              state <= S_FINISH;
            end else begin
              state <= S_WALK;
            end
          end
        end

        S_WALK: begin
          if (req_q == mkl_pkg::REQ_LIST) begin
            if (list_emit && space) begin
              out_valid       <= 1'b1;
              out_status      <= mkl_pkg::ST_DONE;
              out_kind        <= rd_kind;
              out_mac         <= rd_mac;
              out_entry_valid <= 1'b1;
              out_count       <= cnt + 4'd1;
              out_last        <= list_last;
              cnt             <= cnt + 4'd1;
              if (list_last) begin
                state <= S_IDLE;
              end
            end
          end else begin
            if (hit) begin
              match <= 1'b1;
              midx  <= pidx;
              mkind <= rd_kind;
              state <= S_FINISH;
            end else begin
              if (pend && !used[pidx] && !free_found) begin
                free_found <= 1'b1;
                fidx       <= pidx;
              end
              if (at_end) begin
                state <= S_FINISH;
              end
            end
          end

          if (advance) begin
            if (!at_end) begin
              pidx <= idx[AW-1:0];
              idx  <= idx + CW'(1);
              pend <= 1'b1;
            end else begin
              pend <= 1'b0;
            end
          end
        end

        S_FINISH: begin
          if (space) begin
            out_valid       <= 1'b1;
            out_status      <= mkl_pkg::ST_DONE;
            out_kind        <= '0;
            out_mac         <= '0;
            out_entry_valid <= 1'b0;
            out_count       <= '0;
            out_last        <= 1'b1;
            case (req_q)
              mkl_pkg::REQ_LOOKUP: begin
                out_kind        <= match ? mkind : '0;
                out_entry_valid <= match;
              end
              mkl_pkg::REQ_SET: begin
                if (match) begin
                  if (mkind == kval_q) begin
                    out_status <= mkl_pkg::ST_SAME;
                  end
                end else if (free_found) begin
                  used[fidx] <= 1'b1;
                end else begin
                  out_status <= mkl_pkg::ST_FULL;
                end
              end
              mkl_pkg::REQ_CLEAR: begin
                used <= '0;
              end
              default: begin
                // An empty list answers with a single bare beat.
              end
            endcase
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A list walk only starts with at least one used slot, so it always meets
  // a last entry before running off the end of the table.
  a_list_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && req_q == mkl_pkg::REQ_LIST) |-> (used != '0))
    else $error("list walk running over an empty table");

  // The slot RAM is written only when a set request finishes.
  a_write_only_on_set: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_FINISH && req_q == mkl_pkg::REQ_SET))
    else $error("slot RAM written outside a finishing set");

  // A finishing clear leaves every slot unused.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && space && req_q == mkl_pkg::REQ_CLEAR) |=> (used == '0))
    else $error("used marks not cleared by clear");

  // A list never returns more entries than its cap.
  a_list_within_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && req_q == mkl_pkg::REQ_LIST) |-> (cnt < cap_q))
    else $error("list count reached cap while still walking");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MAC kind lookup table: a request driver and a
// result monitor run against a behavioral copy of the slot store.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int SLOTS      = mkl_pkg::SLOT_COUNT_DEF;
  localparam int CYCLE_CAP  = 200000;
  localparam int KEY_POOL_N = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 30;

  // One request beat as the driver puts it on the bus.
  typedef struct {
    mkl_pkg::req_t              op;
    logic [mkl_pkg::MAC_W-1:0]  mac;
    logic [mkl_pkg::KIND_W-1:0] kind;
    logic [mkl_pkg::CNT_W-1:0]  cap;
  } table_req_t;

  // One result beat as the block should return it.
  typedef struct {
    logic [mkl_pkg::ST_W-1:0]   status;
    logic [mkl_pkg::KIND_W-1:0] kind;
    logic [mkl_pkg::MAC_W-1:0]  mac;
    logic                       entry_valid;
    logic [mkl_pkg::CNT_W-1:0]  count;
    logic                       last;
  } table_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mkl_req_if req_ch ();
  mkl_rsp_if rsp_ch ();

  mac_kind_lookup_table_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table. Key and kind entries are only ever read for
  // slots whose used mark is set, so their initial contents do not matter.
  logic [mkl_pkg::MAC_W-1:0]  shadow_mac  [SLOTS];
  logic [mkl_pkg::KIND_W-1:0] shadow_kind [SLOTS];
  logic                       shadow_used [SLOTS];

  table_req_t pending_reqs[$];   // requests not yet put on the bus
  table_rsp_t expected_rsps[$];  // results still owed by the block
  table_req_t on_bus;            // request currently offered to the block

  logic [mkl_pkg::MAC_W-1:0] key_pool [KEY_POOL_N];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_left;
  int mismatches = 0;
  int rsp_beats = 0;
  int cycles = 0;

  task automatic note_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  function automatic int match_slot(input logic [mkl_pkg::MAC_W-1:0] key);
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_used[i] && shadow_mac[i] == key) return i;
    end
    return -1;
  endfunction

  // Applies one accepted request to the shadow table and queues the result
  // beats that it owes.
  function automatic void predict_table_request(input table_req_t rq);
    table_rsp_t r;
    int slot;
    int n;
    logic [mkl_pkg::CNT_W-1:0] cap;
    r = '{status: mkl_pkg::ST_DONE, kind: '0, mac: '0, entry_valid: 1'b0, count: '0,
          last: 1'b1};
    case (rq.op)
      mkl_pkg::REQ_LOOKUP: begin
        slot = match_slot(rq.mac);
        if (slot >= 0) begin
          r.kind = shadow_kind[slot];
          r.entry_valid = 1'b1;
        end
        expected_rsps.push_back(r);
      end
      mkl_pkg::REQ_SET: begin
        slot = match_slot(rq.mac);
        if (slot >= 0) begin
          if (shadow_kind[slot] == rq.kind) r.status = mkl_pkg::ST_SAME;
          else shadow_kind[slot] = rq.kind;
        end else begin
          slot = -1;
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!shadow_used[i]) slot = i;
          end
          if (slot < 0) begin
            r.status = mkl_pkg::ST_FULL;
          end else begin
            shadow_mac[slot]  = rq.mac;
            shadow_kind[slot] = rq.kind;
            shadow_used[slot] = 1'b1;
          end
        end
        expected_rsps.push_back(r);
      end
      mkl_pkg::REQ_LIST: begin
        cap = (rq.cap > mkl_pkg::MAX_RESULTS) ? mkl_pkg::MAX_RESULTS : rq.cap;
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_used[i] && n < cap) begin
            n++;
            r.kind = shadow_kind[i];
            r.mac = shadow_mac[i];
            r.entry_valid = 1'b1;
            r.count = mkl_pkg::CNT_W'(n);
            r.last = 1'b0;
            expected_rsps.push_back(r);
          end
        end
        if (n == 0) expected_rsps.push_back(r);
        else expected_rsps[expected_rsps.size() - 1].last = 1'b1;
      end
      default: begin
        // Clear drops every used mark; stored keys become unreachable.
        for (int i = 0; i < SLOTS; i++) shadow_used[i] = 1'b0;
        expected_rsps.push_back(r);
      end
    endcase
  endfunction

  // Random requests are mostly sets and lookups on a small key pool so that
  // the table fills, hits, repeats values and overflows. Some keys differ
  // from a pool key in one bit to catch partial key compares.
  function automatic table_req_t random_table_request();
    table_req_t rq;
    int pick;
    pick = $urandom_range(99);
    if (pick < 38) rq.op = mkl_pkg::REQ_LOOKUP;
    else if (pick < 76) rq.op = mkl_pkg::REQ_SET;
    else if (pick < 95) rq.op = mkl_pkg::REQ_LIST;
    else rq.op = mkl_pkg::REQ_CLEAR;
    pick = $urandom_range(99);
    rq.mac = key_pool[$urandom_range(KEY_POOL_N - 1)];
    if (pick >= 85) rq.mac = {16'($urandom), 32'($urandom)};
    else if (pick >= 70) rq.mac ^= (48'd1 << $urandom_range(mkl_pkg::MAC_W - 1));
    rq.kind = $urandom_range(1) ? mkl_pkg::KIND_W'($urandom_range(3))
                                : mkl_pkg::KIND_W'($urandom);
    rq.cap = mkl_pkg::CNT_W'($urandom_range(15));
    return rq;
  endfunction

  function automatic table_req_t make_req(input mkl_pkg::req_t op,
                                          input logic [mkl_pkg::MAC_W-1:0] mac,
                                          input logic [mkl_pkg::KIND_W-1:0] kind,
                                          input logic [mkl_pkg::CNT_W-1:0] cap);
    table_req_t rq;
    rq = '{op: op, mac: mac, kind: kind, cap: cap};
    return rq;
  endfunction

  // Request driver. A beat stays on the bus until the block takes it; only
  // then may the sender pause or move on to the next pending request.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= mkl_pkg::REQ_LOOKUP;
      req_ch.mac_key <= '0;
      req_ch.kind_value <= '0;
      req_ch.list_cap <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) predict_table_request(on_bus);
      if (req_ch.valid && !req_ch.ready) begin
        // Hold the current beat.
      end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        on_bus = pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.req_type <= on_bus.op;
        req_ch.mac_key <= on_bus.mac;
        req_ch.kind_value <= on_bus.kind;
        req_ch.list_cap <= on_bus.cap;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering beats
  // while the block backs up and drops its request ready.
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= !hold_go && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  task automatic check_field(input string name, input logic [mkl_pkg::MAC_W-1:0] got,
                             input logic [mkl_pkg::MAC_W-1:0] want);
    if (got !== want)
      note_mismatch($sformatf("result beat %0d: %s is %0h, expected %0h",
                              rsp_beats, name, got, want));
  endtask

  // Result monitor: every accepted beat is checked against the oldest
  // expectation.
  always @(posedge clk) begin
    table_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        note_mismatch($sformatf("result beat %0d arrived with nothing expected", rsp_beats));
      end else begin
        want = expected_rsps.pop_front();
        check_field("status", rsp_ch.status, want.status);
        check_field("kind_out", rsp_ch.kind_out, want.kind);
        check_field("mac_out", rsp_ch.mac_out, want.mac);
        check_field("entry_valid", rsp_ch.entry_valid, want.entry_valid);
        check_field("entry_count", rsp_ch.entry_count, want.count);
        check_field("last", rsp_ch.last, want.last);
      end
      rsp_beats++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Waits until every queued request has been taken and answered.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
      @(negedge clk);
  endtask

  // Stimulus. Phase changes and queue pushes happen at the falling edge so
  // they never race the clocked driver and monitor.
  initial begin
    int idle_plan [4];
    int stall_plan [4];
    logic [mkl_pkg::MAC_W-1:0] ones;
    idle_plan = '{0, 75, 0, 22};
    stall_plan = '{0, 0, 75, 22};
    ones = '1;
    for (int i = 0; i < SLOTS; i++) shadow_used[i] = 1'b0;
    for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = {16'($urandom), 32'($urandom)};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, run with no idling on either side.
    pending_reqs.push_back(make_req(mkl_pkg::REQ_LOOKUP, '0, 8'h00, 4'd0)); // miss, empty
    pending_reqs.push_back(make_req(mkl_pkg::REQ_LIST, '0, 8'h00, 4'd8));   // list, empty
    pending_reqs.push_back(make_req(mkl_pkg::REQ_SET, ones, 8'hFF, 4'd0));  // all-ones
    pending_reqs.push_back(make_req(mkl_pkg::REQ_SET, '0, 8'h00, 4'd0));    // all-zero
    pending_reqs.push_back(make_req(mkl_pkg::REQ_LOOKUP, ones, 8'h00, 4'd0));
    pending_reqs.push_back(make_req(mkl_pkg::REQ_LOOKUP, '0, 8'h00, 4'd0)); // hit, kind zero
    pending_reqs.push_back(make_req(mkl_pkg::REQ_SET, ones, 8'hFF, 4'd0));  // same value
    pending_reqs.push_back(make_req(mkl_pkg::REQ_SET, ones, 8'h5A, 4'd0));  // kind rewritten
    for (int i = 0; i < SLOTS - 2; i++)
      pending_reqs.push_back(make_req(mkl_pkg::REQ_SET, key_pool[i], 8'(8'h10 + i), 4'd0));
    pending_reqs.push_back(make_req(mkl_pkg::REQ_SET, key_pool[SLOTS], 8'h77, 4'd0)); // full
    pending_reqs.push_back(make_req(mkl_pkg::REQ_SET, key_pool[0], 8'hA5, 4'd0)); // update
    pending_reqs.push_back(make_req(mkl_pkg::REQ_LIST, '0, 8'h00, 4'd0));    // cap zero
    pending_reqs.push_back(make_req(mkl_pkg::REQ_LIST, ones, 8'hFF, 4'd15)); // cap saturates
    pending_reqs.push_back(make_req(mkl_pkg::REQ_LIST, '0, 8'h00, 4'd3));
    pending_reqs.push_back(make_req(mkl_pkg::REQ_CLEAR, ones, 8'hFF, 4'd15));
    pending_reqs.push_back(make_req(mkl_pkg::REQ_LOOKUP, ones, 8'h00, 4'd0)); // after clear
    pending_reqs.push_back(make_req(mkl_pkg::REQ_LIST, '0, 8'h00, 4'd8));
    pending_reqs.push_back(make_req(mkl_pkg::REQ_CLEAR, '0, 8'h00, 4'd0));   // empty clear
    wait_drained();

    // Back-pressure: the receiver holds off for a long stretch while a burst
    // of requests is offered, so the block stalls its input.
    hold_go = 1'b1;
    repeat (40) pending_reqs.push_back(random_table_request());
    @(negedge clk);
    hold_go = 1'b0;
    wait_drained();

    // Random part, one phase for each idling plan after the first.
    for (int ph = 1; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      repeat (50) pending_reqs.push_back(random_table_request());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_rsps.size() != 0)
      note_mismatch($sformatf("%0d result beats never arrived", expected_rsps.size()));
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
src/mkl_pkg.sv
src/mkl_req_if.sv
src/mkl_rsp_if.sv
src/mkl_ram.sv
src/mac_kind_lookup_table_top.sv
bench/tb_top.sv
